FILE: rtl/pclr_pkg.sv
// ----------------------------------------------------------------------------
// pclr_pkg: shared definitions for the pot level change reporter
// Register indexes, field widths and the fixed scaling constants of the
// sample-to-level mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package pclr_pkg;

   // ADC range and deadband
   localparam int ADC_MIN  = 0;
   localparam int ADC_MAX  = 4095;
   localparam int DEADBAND = 205;

   localparam int CLAMP_LO = ADC_MIN + DEADBAND;
   localparam int CLAMP_HI = ADC_MAX - DEADBAND;
   localparam int SPAN     = CLAMP_HI - CLAMP_LO;
   localparam bit SPAN_OK  = (SPAN > 0);

   // divisor used by the reciprocal multiply (kept legal when span is empty)
   localparam int DIV_SPAN  = SPAN_OK ? SPAN : 1;
   localparam int DIV_SHIFT = 32 + $clog2(DIV_SPAN);

   // round-up reciprocal: exact floor(n / DIV_SPAN) for any 32-bit n
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << DIV_SHIFT) + 64'(DIV_SPAN) - 64'd1) / 64'(DIV_SPAN);
   localparam logic [32:0] RECIP = RECIP_WIDE[32:0];

   localparam int LEVEL_W  = 16;
   localparam int SAMPLE_W = 12;
   localparam int TIME_W   = 32;
   localparam int TID_W    = 8;
   localparam int INST_W   = 8;

   localparam logic signed [LEVEL_W-1:0] LEVEL_LOW = 16'sh8000;

   // reset values of the control registers
   localparam logic [15:0] MIN_CHANGE_RST = 16'd512;
   localparam logic [15:0] INTERVAL_RST   = 16'd50;
   localparam logic [TIME_W-1:0] LAST_REPORT_RST = 32'hFFFF_FFFF;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_CHANGE     = 2'd0,
      CSR_INTERVAL_MS    = 2'd1,
      CSR_INSTANCE_INDEX = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

FILE: rtl/pot_level_change_reporter.sv
// ----------------------------------------------------------------------------
// pot_level_change_reporter: potentiometer level change reporter
// Gates samples by a minimum report interval, maps them to a signed level
// and reports level changes with a rolling transaction id.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  req_     | in        | req_tvalid/req_tready  | now_ms, sample
//  rsp_     | out       | rsp_tvalid/rsp_tready  | level, transaction_id,
//           |           |                        | instance_out
//  csr_     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
//  One sample per cycle sustained. Three register stages: input, mapped
//  level (after the reciprocal multiply) and result; a reporting sample
//  raises rsp_tvalid once loaded into the result register. Report decision
//  and state update sit in the last stage, so each sample sees the state
//  left by the one before. Synchronous active-high reset, ready right after.
//  A waiting result stalls the pipe only when the next sample also reports.
// ----------------------------------------------------------------------------
`default_nettype none

module pot_level_change_reporter
   import pclr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [31:0] now_ms, [43:32] sample, [47:44] zero
   input  wire logic [47:0]            req_tdata,

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [15:0] level, [23:16] transaction_id, [31:24] instance_out
   output logic [31:0]                 rsp_tdata,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]            csr_data
);

   // configuration registers
   logic [15:0]       min_change_ff, min_change_in;
   logic [15:0]       interval_ff, interval_in;
   logic [INST_W-1:0] instance_ff, instance_in;

   // stage 1: raw input
   logic                s1_valid_ff, s1_valid_in;
   logic [TIME_W-1:0]   s1_now_ff, s1_now_in;
   logic [SAMPLE_W-1:0] s1_sample_ff, s1_sample_in;

   // stage 2: mapped level
   logic                      s2_valid_ff, s2_valid_in;
   logic [TIME_W-1:0]         s2_now_ff, s2_now_in;
   logic signed [LEVEL_W-1:0] s2_level_ff, s2_level_in;

   // reporter state
   logic signed [LEVEL_W-1:0] prev_level_ff, prev_level_in;
   logic                      prev_valid_ff, prev_valid_in;
   logic [TIME_W-1:0]         last_report_ff, last_report_in;
   logic [TID_W-1:0]          tid_ff, tid_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic [TID_W-1:0]          rsp_tid_ff, rsp_tid_in;
   logic [INST_W-1:0]         rsp_inst_ff, rsp_inst_in;

   logic                      req_fire;
   logic                      s2_ready;
   logic                      s2_retire;
   logic                      out_free;
   logic signed [LEVEL_W-1:0] mapped_level;
   logic [TIME_W-1:0]         elapsed;
   logic                      time_ok;
   logic signed [16:0]        diff;
   logic [16:0]               diff_mag;
   logic                      report;

   pclr_map u_map (
      .sample (s1_sample_ff),
      .level  (mapped_level)
   );

   // ---------------- handshake ----------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_retire  = s2_valid_ff && (!report || out_free);
   assign s2_ready   = !s2_valid_ff || s2_retire;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------- report decision ----------------
   // wrapping time difference; a timestamp that runs backwards reads as long
   assign elapsed  = s2_now_ff - last_report_ff;
   assign time_ok  = elapsed >= {16'd0, interval_ff};
   assign diff     = {s2_level_ff[15], s2_level_ff} - {prev_level_ff[15], prev_level_ff};
   assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
   assign report   = time_ok && prev_valid_ff &&
                     ((diff_mag > {1'b0, min_change_ff}) ||
                      (s2_level_ff == 16'sd0 && prev_level_ff != 16'sd0));

   // ---------------- configuration ----------------
   always_comb begin
      min_change_in = min_change_ff;
      interval_in   = interval_ff;
      instance_in   = instance_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_CHANGE:     min_change_in = csr_data;
            CSR_INTERVAL_MS:    interval_in   = csr_data;
            CSR_INSTANCE_INDEX: instance_in   = csr_data[INST_W-1:0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   // ---------------- pipeline next state ----------------
   always_comb begin
      s1_valid_in  = req_fire || (s1_valid_ff && !s2_ready);
      s1_now_in    = req_fire ? req_tdata[31:0] : s1_now_ff;
      s1_sample_in = req_fire ? req_tdata[43:32] : s1_sample_ff;

      s2_valid_in  = (s1_valid_ff && s2_ready) || (s2_valid_ff && !s2_retire);
      s2_now_in    = (s1_valid_ff && s2_ready) ? s1_now_ff : s2_now_ff;
      s2_level_in  = (s1_valid_ff && s2_ready) ? mapped_level : s2_level_ff;
   end

   // ---------------- state and result ----------------
   always_comb begin
      prev_level_in  = prev_level_ff;
      prev_valid_in  = prev_valid_ff;
      last_report_in = last_report_ff;
      tid_in         = tid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_level_in   = rsp_level_ff;
      rsp_tid_in     = rsp_tid_ff;
      rsp_inst_in    = rsp_inst_ff;

      if (s2_retire && time_ok) begin
         if (!prev_valid_ff) begin
            // first level only primes the stored value
            prev_level_in = s2_level_ff;
            prev_valid_in = 1'b1;
         end else if (report) begin
            prev_level_in  = s2_level_ff;
            last_report_in = s2_now_ff;
            tid_in         = tid_ff + 8'd1;
            rsp_valid_in   = 1'b1;
            rsp_level_in   = s2_level_ff;
            rsp_tid_in     = tid_ff + 8'd1;
            rsp_inst_in    = instance_ff;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_change_ff  <= MIN_CHANGE_RST;
         interval_ff    <= INTERVAL_RST;
         instance_ff    <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         prev_level_ff  <= LEVEL_LOW;
         prev_valid_ff  <= 1'b0;
         last_report_ff <= LAST_REPORT_RST;
         tid_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         min_change_ff  <= min_change_in;
         interval_ff    <= interval_in;
         instance_ff    <= instance_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         prev_level_ff  <= prev_level_in;
         prev_valid_ff  <= prev_valid_in;
         last_report_ff <= last_report_in;
         tid_ff         <= tid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_now_ff    <= s1_now_in;
      s1_sample_ff <= s1_sample_in;
      s2_now_ff    <= s2_now_in;
      s2_level_ff  <= s2_level_in;
      rsp_level_ff <= rsp_level_in;
      rsp_tid_ff   <= rsp_tid_in;
      rsp_inst_ff  <= rsp_inst_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_inst_ff, rsp_tid_ff, rsp_level_ff};

endmodule

`default_nettype wire

FILE: rtl/pclr_map.sv
// ----------------------------------------------------------------------------
// pclr_map: sample to level mapping
// Clamps the raw sample into the deadband window and scales it onto the
// signed 16-bit range with a constant reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module pclr_map
   import pclr_pkg::*;
(
   input  wire logic [SAMPLE_W-1:0]       sample,
   output logic signed [LEVEL_W-1:0]      level
);

   logic [16:0] x_clamped;
   logic [15:0] offset;
   logic [31:0] numer;
   logic [64:0] prod;
   logic [15:0] quot;

   always_comb begin
      x_clamped = {5'd0, sample};
      if (x_clamped < 17'(CLAMP_LO)) begin
         x_clamped = 17'(CLAMP_LO);
      end
      if (x_clamped > 17'(CLAMP_HI)) begin
         x_clamped = 17'(CLAMP_HI);
      end
   end

   // value lies in [CLAMP_LO, CLAMP_HI] whenever the span is non-empty
   assign offset = 16'(x_clamped - 17'(CLAMP_LO));

   // offset * 65535 as shift and subtract
   assign numer = {offset, 16'd0} - {16'd0, offset};
   assign prod  = 65'(numer) * 65'(RECIP);
   assign quot  = prod[DIV_SHIFT +: 16];

   // quot - 32768 is quot with the top bit flipped
   assign level = SPAN_OK ? $signed({~quot[15], quot[14:0]}) : LEVEL_LOW;

endmodule

`default_nettype wire

FILE: rtl/pclr_checker.sv
// ----------------------------------------------------------------------------
// pclr_checker: port-level checks for the pot level change reporter
// Watches the result channel for reset behavior, stall stability and the
// transaction id sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module pclr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   logic [7:0] exp_tid_ff, exp_tid_in;

   assign exp_tid_in = (rsp_tvalid && rsp_tready) ? rsp_tdata[23:16] : exp_tid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_tid_ff <= '0;
      end else begin
         exp_tid_ff <= exp_tid_in;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   a_tid_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |-> (rsp_tdata[23:16] == exp_tid_ff + 8'd1))
      else $error("transaction id skipped or repeated");

endmodule

bind pot_level_change_reporter pclr_checker u_pclr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
